FILE: rtl/core/wtr_pkg.sv
// shared types and constants for the wavelet tree rank block
`timescale 1ns / 1ps
`default_nettype none
package wtr_pkg;

	localparam int SymW   = 8;
	localparam int PosW   = 10;
	localparam int CountW = 11;
	localparam int SigmaW = 9;
	localparam logic [SigmaW-1:0] MaxSigma = 9'd256;

	localparam logic ActAppend = 1'b0;
	localparam logic ActQuery  = 1'b1;

	typedef struct packed {
		logic            action;
		logic [SymW-1:0] symbol;
		logic [PosW-1:0] position;
		logic            last;
	} in_item_t;

	typedef struct packed {
		logic [CountW-1:0] count;
		logic              error;
	} out_item_t;

	// controller to datapath
	typedef struct packed {
		logic take;
		logic issue;
		logic emit;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic is_query;
		logic q_err;
		logic scan_last;
		logic out_free;
	} stat_t;

endpackage
`default_nettype wire

FILE: rtl/core/wtr_ctrl.sv
// sequencer for append, query scan and result hand-off
`timescale 1ns / 1ps
`default_nettype none
module wtr_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_stall,
	input  wire wtr_pkg::stat_t st,
	output wtr_pkg::cmd_t      cmd
);

	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_SCAN  = 4'b0010,
		S_DRAIN = 4'b0100,
		S_DONE  = 4'b1000
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d   = state_q;
		cmd.take  = 1'b0;
		cmd.issue = 1'b0;
		cmd.emit  = 1'b0;
		in_stall  = (state_q != S_IDLE);
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.take = 1'b1;
					if (st.is_query) begin
						state_d = st.q_err ? S_DONE : S_SCAN;
					end
				end
			end
			S_SCAN: begin
				cmd.issue = 1'b1;
				if (st.scan_last) begin
					state_d = S_DRAIN;
				end
			end
			S_DRAIN: begin
				state_d = S_DONE;
			end
			S_DONE: begin
				if (st.out_free) begin
					cmd.emit = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	a_query_scans: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.take && st.is_query && !st.q_err |=> state_q == S_SCAN)
		else $error("valid query did not start a scan");

	a_err_skips: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.take && st.is_query && st.q_err |=> state_q == S_DONE)
		else $error("failed query did not go to result");

	a_append_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.take && !st.is_query |=> state_q == S_IDLE)
		else $error("append left idle");

endmodule
`default_nettype wire

FILE: rtl/core/wtr_dp.sv
// symbol store, length and alphabet registers, rank scan counter, result register
`timescale 1ns / 1ps
`default_nettype none
module wtr_dp #(
	parameter int MAX_LENGTH = 1024
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire wtr_pkg::in_item_t   in_data,
	input  wire logic                cfg_we,
	input  wire logic [wtr_pkg::SigmaW-1:0] cfg_wdata,
	input  wire wtr_pkg::cmd_t       cmd,
	output wtr_pkg::stat_t           st,
	output logic                     out_valid,
	input  wire logic                out_stall,
	output wtr_pkg::out_item_t       out_data
);

	localparam int AW = (MAX_LENGTH > 1) ? $clog2(MAX_LENGTH) : 1;
	localparam int LW = $clog2(MAX_LENGTH + 1);
	localparam int CW = (LW > wtr_pkg::PosW) ? LW : wtr_pkg::PosW;
	localparam logic [LW-1:0] Full = LW'(MAX_LENGTH);

	logic [wtr_pkg::SymW-1:0] mem [MAX_LENGTH];

	logic [LW-1:0]               len_q;
	logic                        built_q;
	logic [wtr_pkg::SigmaW-1:0]  alpha_q;
	logic [wtr_pkg::SigmaW-1:0]  sigma_q;
	logic [wtr_pkg::SymW-1:0]    sym_q;
	logic [wtr_pkg::PosW-1:0]    pos_q;
	logic                        err_q;
	logic [AW-1:0]               k_q;
	logic [wtr_pkg::SymW-1:0]    rd_s1;
	logic                        rd_vld_s1;
	logic [wtr_pkg::CountW-1:0]  cnt_q;
	logic                        out_valid_q;
	wtr_pkg::out_item_t          out_q;

	logic [wtr_pkg::SigmaW-1:0]  eff_sigma;
	logic [wtr_pkg::SigmaW-1:0]  top;
	logic [wtr_pkg::SigmaW-1:0]  rd_clamp;
	logic [AW-1:0]               wr_addr;
	logic                        wr_ok;
	logic                        hit;

	always_comb begin
		eff_sigma = alpha_q;
		if (alpha_q == '0) begin
			eff_sigma = wtr_pkg::SigmaW'(1);
		end else if (alpha_q > wtr_pkg::MaxSigma) begin
			eff_sigma = wtr_pkg::MaxSigma;
		end
	end

	// a built tree is dropped by the next append
	assign wr_addr = built_q ? '0 : len_q[AW-1:0];
	assign wr_ok   = built_q || (len_q != Full);

	assign st.is_query = (in_data.action == wtr_pkg::ActQuery);
	assign st.q_err    = !built_q
		|| (CW'(in_data.position) >= CW'(len_q))
		|| ({1'b0, in_data.symbol} >= sigma_q);
	assign st.scan_last = (CW'(k_q) == CW'(pos_q));
	assign st.out_free  = !out_valid_q || !out_stall;

	// stored symbols above the alphabet rank as the top symbol
	assign top      = sigma_q - wtr_pkg::SigmaW'(1);
	assign rd_clamp = ({1'b0, rd_s1} > top) ? top : {1'b0, rd_s1};
	assign hit      = (rd_clamp == {1'b0, sym_q});

	always_ff @(posedge clk) begin
		if (cmd.take && !st.is_query && wr_ok) begin
			mem[wr_addr] <= in_data.symbol;
		end
		rd_s1 <= mem[k_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q       <= '0;
			built_q     <= 1'b0;
			alpha_q     <= wtr_pkg::SigmaW'(2);
			sigma_q     <= wtr_pkg::SigmaW'(1);
			k_q         <= '0;
			rd_vld_s1   <= 1'b0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				alpha_q <= cfg_wdata;
			end
			rd_vld_s1 <= cmd.issue;
			if (cmd.take && !st.is_query) begin
				if (wr_ok) begin
					len_q <= LW'(wr_addr) + LW'(1);
				end else if (built_q) begin
					len_q <= '0;
				end
				built_q <= in_data.last;
				if (in_data.last) begin
					sigma_q <= eff_sigma;
				end
			end
			if (cmd.take) begin
				k_q   <= '0;
				cnt_q <= '0;
			end else begin
				if (cmd.issue) begin
					k_q <= k_q + AW'(1);
				end
				if (rd_vld_s1 && hit) begin
					cnt_q <= cnt_q + wtr_pkg::CountW'(1);
				end
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			sym_q <= in_data.symbol;
			pos_q <= in_data.position;
			err_q <= st.q_err;
		end
		if (cmd.emit) begin
			out_q.count <= err_q ? '0 : cnt_q;
			out_q.error <= err_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	a_issue_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.issue |-> CW'(k_q) <= CW'(pos_q))
		else $error("scan ran past the query position");

	a_emit_drained: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> !rd_vld_s1 && !cmd.issue)
		else $error("result taken before scan finished");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> !out_valid_q || !out_stall)
		else $error("waiting result overwritten");

endmodule
`default_nettype wire

FILE: rtl/core/wavelet_tree_rank.sv
// top level of the wavelet tree rank block
//
//  channel   direction  handshake            payload
//  in        input      in_valid/in_stall    wtr_pkg::in_item_t
//  out       output     out_valid/out_stall  wtr_pkg::out_item_t
//  cfg       input      cfg_we               cfg_wdata, alphabet size
//
// an append item leaves the sequencer idle; the last append latches the alphabet size
// a query item is taken, then each stored symbol up to and including its position is read
// from the single read port of the store, then the read is drained and the result is loaded
// a query that fails its checks skips the scan and goes straight to the result
// reset clears length, built flag and result valid and sets the alphabet size to 2; the store needs no clearing
// a finished result waits in the output register while the next item is taken
`timescale 1ns / 1ps
`default_nettype none
module wavelet_tree_rank #(
	parameter int MAX_LENGTH = 1024
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       in_valid,
	output logic                            in_stall,
	input  wire wtr_pkg::in_item_t          in_data,
	output logic                            out_valid,
	input  wire logic                       out_stall,
	output wtr_pkg::out_item_t              out_data,
	input  wire logic                       cfg_we,
	input  wire logic [wtr_pkg::SigmaW-1:0] cfg_wdata
);

	// command and status between sequencer and datapath
	wtr_pkg::cmd_t  cmd;
	wtr_pkg::stat_t st;

	// sequencer: idle, scan of the store, drain, result hand-off
	wtr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.st       (st),
		.cmd      (cmd)
	);

	// datapath: store, length, alphabet, counter, output register
	wtr_dp #(
		.MAX_LENGTH (MAX_LENGTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_data),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.cmd       (cmd),
		.st        (st),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule
`default_nettype wire
